FILE: hw/rtl/anms_pkg.sv
package anms_pkg;

    typedef struct packed {
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic [31:0] point_response;
        logic        last_point;
    } point_t;

    typedef struct packed {
        logic [15:0] kept_x;
        logic [15:0] kept_y;
        logic [31:0] kept_response;
        logic        last_kept;
        logic        dropped_flag;
    } result_t;

    // one stored keypoint
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [31:0] s;
    } entry_t;

    localparam logic REG_KEEP_COUNT   = 1'b0;
    localparam logic REG_ROBUST_COEFF = 1'b1;

    localparam logic [5:0]  KEEP_COUNT_RST   = 6'd32;
    localparam logic [8:0]  ROBUST_COEFF_RST = 9'd284;
    localparam logic [33:0] RADIUS_MAX       = 34'h3_FFFF_FFFF;

endpackage

FILE: hw/rtl/adaptive_nonmax_suppression.sv
// adaptive non-maximal suppression over one set of keypoints
//
// input: a point is transferred at a clock edge with start high and busy low.
// points are stored one per cycle; busy stays low while a set is loading.
// the point that carries last_point raises busy and starts processing.
// points beyond MAX_POINTS are dropped and dropped_flag is set on every
// result of that set.
// output: each retained point shows on result for one cycle with valid high;
// the receiver cannot stall, results are never held.
// a set of n points with n <= keep_count is returned in input order, each point
// through a read state and an output state. larger sets are ranked by response,
// then each point gets its suppression radius from a scan over the stronger
// points, then each radius is ranked against all others; every phase is a scan
// over the stored set through one read port of a registered-read memory.
// keep_count and robust_coeff are written through wr_en/wr_index/wr_data; the
// user writes them only while busy is low and no set is in flight, which the
// block itself does not enforce.
// reset clears the point count, the drop flag and the registers to defaults;
// the point memories need no clearing.
module adaptive_nonmax_suppression #(
    parameter int MAX_POINTS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  anms_pkg::point_t      point,
    output logic                  valid,
    output anms_pkg::result_t     result,
    input  logic                  wr_en,
    input  logic                  wr_index,
    input  logic [8:0]            wr_data
);

    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam logic [CNTW-1:0] NMAX = CNTW'(MAX_POINTS);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_SM_RD   = 5'd1;
    localparam logic [4:0] S_SM_OUT  = 5'd2;
    localparam logic [4:0] S_RK_LD   = 5'd3;
    localparam logic [4:0] S_RK_HOLD = 5'd4;
    localparam logic [4:0] S_RK_SCAN = 5'd5;
    localparam logic [4:0] S_RK_WR   = 5'd6;
    localparam logic [4:0] S_RA_LD   = 5'd7;
    localparam logic [4:0] S_RA_HOLD = 5'd8;
    localparam logic [4:0] S_RA_SCAN = 5'd9;
    localparam logic [4:0] S_RA_WR   = 5'd10;
    localparam logic [4:0] S_KS_LD   = 5'd11;
    localparam logic [4:0] S_KS_HOLD = 5'd12;
    localparam logic [4:0] S_KS_SCAN = 5'd13;
    localparam logic [4:0] S_KS_DEC  = 5'd14;
    localparam logic [4:0] S_KS_GET  = 5'd15;
    localparam logic [4:0] S_FIN     = 5'd16;
    localparam logic [4:0] S_DONE    = 5'd17;

    anms_pkg::entry_t pt_mem  [MAX_POINTS];
    anms_pkg::entry_t srt_mem [MAX_POINTS];
    logic [33:0]      rad_mem [MAX_POINTS];

    anms_pkg::entry_t pt_rd_reg;
    anms_pkg::entry_t srt_rd_reg;
    logic [33:0]      rad_rd_reg;

    logic [4:0]       state_reg;
    logic [5:0]       keep_reg;
    logic [8:0]       coeff_reg;
    logic [CNTW-1:0]  count_reg;
    logic             ovf_reg;
    logic [CNTW-1:0]  i_reg;
    logic [CNTW-1:0]  j_reg;
    logic [CNTW-1:0]  jd_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             p1_reg;
    logic             p2_reg;
    logic             flag_reg;
    logic [31:0]      dx2_reg;
    logic [31:0]      dy2_reg;
    logic [33:0]      r_reg;
    logic [33:0]      cur_r_reg;
    logic [40:0]      lim_reg;
    anms_pkg::entry_t cur_reg;
    anms_pkg::entry_t pend_reg;
    logic             pend_v_reg;
    logic             valid_reg;
    anms_pkg::result_t result_reg;

    logic [AW-1:0]    pt_raddr;
    logic [AW-1:0]    srt_raddr;
    logic [AW-1:0]    rad_raddr;
    logic             accept;
    logic [CNTW-1:0]  i_inc;
    logic             rk_hit;
    logic [15:0]      dx;
    logic [15:0]      dy;
    logic [32:0]      dist_sq;
    logic             keep_it;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign valid  = valid_reg;
    assign result = result_reg;
    assign i_inc  = i_reg + CNTW'(1);

    assign pt_raddr  = (state_reg == S_RK_SCAN) ? j_reg[AW-1:0] : i_reg[AW-1:0];
    assign srt_raddr = (state_reg == S_RA_SCAN) ? j_reg[AW-1:0] : i_reg[AW-1:0];
    assign rad_raddr = (state_reg == S_KS_SCAN) ? j_reg[AW-1:0] : i_reg[AW-1:0];

    // stable descending rank: stronger points, or equal ones that came first
    assign rk_hit = p1_reg && ((pt_rd_reg.s > cur_reg.s) ||
                    ((pt_rd_reg.s == cur_reg.s) && (jd_reg < i_reg)));

    assign dx   = (srt_rd_reg.x >= cur_reg.x) ? srt_rd_reg.x - cur_reg.x
                                               : cur_reg.x - srt_rd_reg.x;
    assign dy   = (srt_rd_reg.y >= cur_reg.y) ? srt_rd_reg.y - cur_reg.y
                                               : cur_reg.y - srt_rd_reg.y;
    assign dist_sq = {1'b0, dx2_reg} + {1'b0, dy2_reg};

    // kept when at most keep_count radii are strictly larger
    assign keep_it = (32'(cnt_reg) <= 32'(keep_reg));

    always_ff @(posedge clk)
    begin
        pt_rd_reg  <= pt_mem[pt_raddr];
        srt_rd_reg <= srt_mem[srt_raddr];
        rad_rd_reg <= rad_mem[rad_raddr];
        if (accept && (count_reg < NMAX))
        begin
            pt_mem[count_reg[AW-1:0]] <= '{x: point.point_x, y: point.point_y,
                                          s: point.point_response};
        end
        if (state_reg == S_RK_WR)
        begin
            srt_mem[cnt_reg[AW-1:0]] <= cur_reg;
        end
        if (state_reg == S_RA_WR)
        begin
            rad_mem[i_reg[AW-1:0]] <= r_reg;
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        jd_reg   <= j_reg;
        flag_reg <= ({1'b0, srt_rd_reg.s, 8'd0} > lim_reg);
        dx2_reg  <= 32'(dx) * 32'(dx);
        dy2_reg  <= 32'(dy) * 32'(dy);
        if (state_reg == S_RK_HOLD)
        begin
            cur_reg <= pt_rd_reg;
        end
        if (state_reg == S_RA_HOLD)
        begin
            cur_reg <= srt_rd_reg;
            lim_reg <= 41'(srt_rd_reg.s) * 41'(coeff_reg);
        end
        if (state_reg == S_KS_HOLD)
        begin
            cur_r_reg <= rad_rd_reg;
        end
        if (state_reg == S_RA_HOLD)
        begin
            r_reg <= anms_pkg::RADIUS_MAX;
        end
        else if (p2_reg && flag_reg && ({1'b0, dist_sq} < r_reg))
        begin
            r_reg <= {1'b0, dist_sq};
        end
        if (state_reg == S_KS_GET)
        begin
            pend_reg <= srt_rd_reg;
        end
        result_reg.dropped_flag <= ovf_reg;
        if (state_reg == S_SM_OUT)
        begin
            result_reg.kept_x        <= pt_rd_reg.x;
            result_reg.kept_y        <= pt_rd_reg.y;
            result_reg.kept_response <= pt_rd_reg.s;
            result_reg.last_kept     <= (i_inc == count_reg);
        end
        else
        begin
            result_reg.kept_x        <= pend_reg.x;
            result_reg.kept_y        <= pend_reg.y;
            result_reg.kept_response <= pend_reg.s;
            result_reg.last_kept     <= (state_reg == S_FIN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            keep_reg   <= anms_pkg::KEEP_COUNT_RST;
            coeff_reg  <= anms_pkg::ROBUST_COEFF_RST;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            cnt_reg    <= '0;
            p1_reg     <= 1'b0;
            p2_reg     <= 1'b0;
            pend_v_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            p1_reg    <= 1'b0;
            p2_reg    <= p1_reg;
            if (wr_en)
            begin
                case (wr_index)
                    anms_pkg::REG_KEEP_COUNT:   keep_reg  <= wr_data[5:0];
                    anms_pkg::REG_ROBUST_COEFF: coeff_reg <= wr_data;
                    default:                    ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        logic [CNTW-1:0] n;
                        n = count_reg;
                        if (count_reg < NMAX)
                        begin
                            n = count_reg + CNTW'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        count_reg <= n;
                        i_reg     <= '0;
                        if (point.last_point)
                        begin
                            if (32'(n) <= 32'(keep_reg))
                            begin
                                state_reg <= S_SM_RD;
                            end
                            else
                            begin
                                state_reg <= S_RK_LD;
                            end
                        end
                    end
                end
                S_SM_RD:
                begin
                    state_reg <= S_SM_OUT;
                end
                S_SM_OUT:
                begin
                    valid_reg <= 1'b1;
                    i_reg     <= i_inc;
                    state_reg <= (i_inc == count_reg) ? S_DONE : S_SM_RD;
                end
                S_RK_LD:
                begin
                    state_reg <= S_RK_HOLD;
                end
                S_RK_HOLD:
                begin
                    j_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_RK_SCAN;
                end
                S_RK_SCAN:
                begin
                    if (rk_hit)
                    begin
                        cnt_reg <= cnt_reg + CNTW'(1);
                    end
                    if (j_reg < count_reg)
                    begin
                        p1_reg <= 1'b1;
                        j_reg  <= j_reg + CNTW'(1);
                    end
                    else if (!p1_reg)
                    begin
                        state_reg <= S_RK_WR;
                    end
                end
                S_RK_WR:
                begin
                    i_reg <= (i_inc == count_reg) ? '0 : i_inc;
                    state_reg <= (i_inc == count_reg) ? S_RA_LD : S_RK_LD;
                end
                S_RA_LD:
                begin
                    state_reg <= S_RA_HOLD;
                end
                S_RA_HOLD:
                begin
                    j_reg     <= '0;
                    state_reg <= S_RA_SCAN;
                end
                S_RA_SCAN:
                begin
                    // stronger points only: indexes below i in sorted order
                    if (j_reg < i_reg)
                    begin
                        p1_reg <= 1'b1;
                        j_reg  <= j_reg + CNTW'(1);
                    end
                    else if (!p1_reg && !p2_reg)
                    begin
                        state_reg <= S_RA_WR;
                    end
                end
                S_RA_WR:
                begin
                    i_reg <= (i_inc == count_reg) ? '0 : i_inc;
                    state_reg <= (i_inc == count_reg) ? S_KS_LD : S_RA_LD;
                end
                S_KS_LD:
                begin
                    state_reg <= S_KS_HOLD;
                end
                S_KS_HOLD:
                begin
                    j_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_KS_SCAN;
                end
                S_KS_SCAN:
                begin
                    if (p1_reg && (rad_rd_reg > cur_r_reg))
                    begin
                        cnt_reg <= cnt_reg + CNTW'(1);
                    end
                    if (j_reg < count_reg)
                    begin
                        p1_reg <= 1'b1;
                        j_reg  <= j_reg + CNTW'(1);
                    end
                    else if (!p1_reg)
                    begin
                        state_reg <= S_KS_DEC;
                    end
                end
                S_KS_DEC:
                begin
                    if (keep_it)
                    begin
                        state_reg <= S_KS_GET;
                    end
                    else
                    begin
                        i_reg     <= i_inc;
                        state_reg <= (i_inc == count_reg) ? S_FIN : S_KS_LD;
                    end
                end
                S_KS_GET:
                begin
                    // the held point goes out once a later one is known kept
                    valid_reg  <= pend_v_reg;
                    pend_v_reg <= 1'b1;
                    i_reg      <= i_inc;
                    state_reg  <= (i_inc == count_reg) ? S_FIN : S_KS_LD;
                end
                S_FIN:
                begin
                    valid_reg  <= pend_v_reg;
                    pend_v_reg <= 1'b0;
                    state_reg  <= S_DONE;
                end
                S_DONE:
                begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: bench/adaptive_nonmax_suppression_tb.sv
`timescale 1ns / 100ps

module adaptive_nonmax_suppression_tb;

    localparam int CAPACITY = 64;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 32;

    class suppression_book;
        logic [15:0] xs [CAPACITY];
        logic [15:0] ys [CAPACITY];
        logic [31:0] ss [CAPACITY];
        int          stored;
        bit          overflow;
        logic [5:0]  keep;
        logic [8:0]  coeff;
        anms_pkg::result_t pending [$];
        int          errors;
        int          sets;
        int          results;

        function new();
            stored = 0;
            overflow = 0;
            keep = anms_pkg::KEEP_COUNT_RST;
            coeff = anms_pkg::ROBUST_COEFF_RST;
            errors = 0;
            sets = 0;
            results = 0;
        endfunction

        function void write_reg(logic idx, logic [8:0] val);
            if (idx == anms_pkg::REG_KEEP_COUNT)
                keep = val[5:0];
            else
                coeff = val;
        endfunction

        function void push_kept(int idx, bit is_last);
            anms_pkg::result_t r;
            r.kept_x = xs[idx];
            r.kept_y = ys[idx];
            r.kept_response = ss[idx];
            r.last_kept = is_last;
            r.dropped_flag = overflow;
            pending.insert(pending.size(), r);
        endfunction

        function longint unsigned sq_gap(logic [15:0] a, logic [15:0] b);
            longint unsigned d;
            d = (a >= b) ? 64'(a - b) : 64'(b - a);
            return d * d;
        endfunction

        function void rank_and_emit();
            int          order [CAPACITY];
            longint unsigned radius [CAPACITY];
            longint unsigned ranked [CAPACITY];
            int          kept [$];
            int          n;
            int          j;
            longint unsigned bound;
            longint unsigned r;
            longint unsigned d;
            longint unsigned cut;
            n = stored;
            sets++;
            if (n <= keep)
            begin
                for (int i = 0; i < n; i++)
                    push_kept(i, i == n - 1);
                return;
            end
            // stable descending order by response
            for (int i = 0; i < n; i++)
            begin
                j = i;
                while (j > 0 && ss[order[j - 1]] < ss[i])
                begin
                    order[j] = order[j - 1];
                    j--;
                end
                order[j] = i;
            end
            for (int i = 0; i < n; i++)
            begin
                bound = 64'(ss[order[i]]) * 64'(coeff);
                r = 64'(anms_pkg::RADIUS_MAX);
                for (int k = 0; k < i; k++)
                begin
                    if ((64'(ss[order[k]]) << 8) > bound)
                    begin
                        d = sq_gap(xs[order[i]], xs[order[k]])
                            + sq_gap(ys[order[i]], ys[order[k]]);
                        if (d < r)
                            r = d;
                    end
                end
                radius[i] = r;
            end
            for (int i = 0; i < n; i++)
            begin
                j = i;
                while (j > 0 && ranked[j - 1] < radius[i])
                begin
                    ranked[j] = ranked[j - 1];
                    j--;
                end
                ranked[j] = radius[i];
            end
            cut = ranked[keep];
            for (int i = 0; i < n; i++)
                if (radius[i] >= cut)
                    kept.insert(kept.size(), order[i]);
            foreach (kept[i])
                push_kept(kept[i], i == kept.size() - 1);
        endfunction

        function void note_point(anms_pkg::point_t p);
            if (stored < CAPACITY)
            begin
                xs[stored] = p.point_x;
                ys[stored] = p.point_y;
                ss[stored] = p.point_response;
                stored++;
            end
            else
            begin
                overflow = 1;
            end
            if (p.last_point)
            begin
                rank_and_emit();
                stored = 0;
                overflow = 0;
            end
        endfunction

        function void check_kept(anms_pkg::result_t got);
            anms_pkg::result_t want;
            results++;
            if (pending.size() == 0)
            begin
                $error("unexpected result x=%h y=%h resp=%h",
                       got.kept_x, got.kept_y, got.kept_response);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.kept_x !== want.kept_x)
            begin
                $error("kept_x expected %h actual %h", want.kept_x, got.kept_x);
                errors++;
            end
            if (got.kept_y !== want.kept_y)
            begin
                $error("kept_y expected %h actual %h", want.kept_y, got.kept_y);
                errors++;
            end
            if (got.kept_response !== want.kept_response)
            begin
                $error("kept_response expected %h actual %h",
                       want.kept_response, got.kept_response);
                errors++;
            end
            if (got.last_kept !== want.last_kept)
            begin
                $error("last_kept expected %b actual %b", want.last_kept, got.last_kept);
                errors++;
            end
            if (got.dropped_flag !== want.dropped_flag)
            begin
                $error("dropped_flag expected %b actual %b",
                       want.dropped_flag, got.dropped_flag);
                errors++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    anms_pkg::point_t  point;
    logic    valid;
    anms_pkg::result_t result;
    logic    wr_en;
    logic    wr_index;
    logic [8:0] wr_data;

    suppression_book book = new();
    int cycles = 0;
    int idle_pct = 0;
    int points_sent = 0;

    adaptive_nonmax_suppression dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .point    (point),
        .valid    (valid),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && valid)
            book.check_kept(result);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("adaptive_nonmax_suppression: mismatch");
            $finish;
        end
    end

    task automatic send_point(anms_pkg::point_t p);
        // idle cycles on the sender side
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        point <= p;
        do
            @(posedge clk);
        while (busy);
        book.note_point(p);
        points_sent++;
    endtask

    // mode 0: full range, 1: clustered with spread responses, 2: heavy ties
    task automatic send_set(int n, int mode);
        anms_pkg::point_t p;
        logic [15:0] bx;
        logic [15:0] by;
        bx = 16'($urandom);
        by = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            p.point_x = 16'($urandom);
            p.point_y = 16'($urandom);
            p.point_response = $urandom;
            if (mode == 1)
            begin
                p.point_x = bx + 16'($urandom_range(0, 200));
                p.point_y = by + 16'($urandom_range(0, 200));
                p.point_response = $urandom_range(1000, 1400);
            end
            else if (mode == 2)
            begin
                p.point_x = bx + 16'($urandom_range(0, 7));
                p.point_response = $urandom_range(0, 3) * 32'h4000_0000;
            end
            p.last_point = (i == n - 1);
            send_point(p);
        end
    endtask

    task automatic drain();
        if (start)
            start <= 1'b0;
        while (book.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        book.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic edge_set();
        anms_pkg::point_t p;
        p = '{16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 1'b0};
        send_point(p);
        p = '{16'h0000, 16'hFFFF, 32'h0000_0000, 1'b0};
        send_point(p);
        p = '{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0};
        send_point(p);
        p = '{16'h0000, 16'h0000, 32'h8000_0000, 1'b1};
        send_point(p);
    endtask

    initial
    begin
        int sz;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        point = '0;
        wr_en = 1'b0;
        wr_index = anms_pkg::REG_KEEP_COUNT;
        wr_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, count at and around keep_count, zero keep
        write_reg(anms_pkg::REG_KEEP_COUNT, 9'd2);
        send_set(1, 0);
        send_set(2, 2);
        edge_set();
        drain();
        write_reg(anms_pkg::REG_KEEP_COUNT, 9'd0);
        write_reg(anms_pkg::REG_ROBUST_COEFF, 9'd256);
        send_set(3, 2);
        drain();
        write_reg(anms_pkg::REG_KEEP_COUNT, 9'd1);
        write_reg(anms_pkg::REG_ROBUST_COEFF, 9'd511);
        edge_set();
        send_set(5, 1);
        drain();
        write_reg(anms_pkg::REG_KEEP_COUNT, 9'd63);
        send_set(4, 0);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 19 : (phase == 1) ? 51 : 0;
            for (int s = 0; s < 6 && points_sent < 60 * (phase + 1); s++)
            begin
                if (s % 3 == 0)
                begin
                    drain();
                    write_reg(anms_pkg::REG_KEEP_COUNT,
                              9'(($urandom_range(3) == 0) ?
                                 $urandom_range(0, 63) : $urandom_range(1, 8)));
                    write_reg(anms_pkg::REG_ROBUST_COEFF, 9'($urandom_range(256, 511)));
                end
                sz = $urandom_range(99);
                if (sz < 12)
                    send_set($urandom_range(64, 68), $urandom_range(0, 2));
                else if (sz < 30)
                    send_set(book.keep + $urandom_range(0, 1), $urandom_range(0, 2));
                else
                    send_set($urandom_range(1, 12), $urandom_range(0, 2));
            end
            // full capacity set, one point over keep_count
            if (phase == 2)
            begin
                drain();
                write_reg(anms_pkg::REG_KEEP_COUNT, 9'd63);
                send_set(64, 1);
            end
        end

        drain();
        $display("covered %0d points in %0d sets, %0d retained points checked",
                 points_sent, book.sets, book.results);
        if (book.errors == 0 && book.pending.size() == 0)
            $display("adaptive_nonmax_suppression: match");
        else
            $display("adaptive_nonmax_suppression: mismatch");
        $finish;
    end

endmodule

FILE: adaptive_nonmax_suppression.f
hw/rtl/anms_pkg.sv
hw/rtl/adaptive_nonmax_suppression.sv
bench/adaptive_nonmax_suppression_tb.sv
